// File: hdl/thc_pkg.sv
// Shared types and constants for the thermostat PWM heater controller.
package thc_pkg;

    localparam int TEMP_W   = 15;
    localparam int RATE_W   = 15;
    localparam int TIME_W   = 32;
    localparam int TARGET_W = 14;
    localparam int MODE_W   = 2;
    localparam int DUTY_W   = 4;
    localparam int ERR_W    = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    localparam int PERIOD_MS_DEFAULT = 10000;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_TEMP  = 2'd1;

    // mode codes; code 3 is unused and acts as off
    localparam logic [MODE_W-1:0] CTRL_OFF    = 2'd0;
    localparam logic [MODE_W-1:0] CTRL_FORCED = 2'd1;
    localparam logic [MODE_W-1:0] CTRL_AUTO   = 2'd2;

    localparam logic [TARGET_W-1:0] TARGET_MIN   = 14'd5000;
    localparam logic [TARGET_W-1:0] TARGET_MAX   = 14'd9000;
    localparam logic [TARGET_W-1:0] TARGET_RESET = 14'd7500;

    // thresholds in hundredths of a degree
    localparam logic signed [ERR_W-1:0] ERR_BAND_8 = 17'sd100;
    localparam logic signed [ERR_W-1:0] ERR_BAND_6 = 17'sd50;
    localparam logic signed [ERR_W-1:0] ERR_BAND_4 = 17'sd20;
    localparam logic signed [ERR_W-1:0] ERR_BAND_2 = 17'sd0;
    localparam logic signed [ERR_W-1:0] ERR_SLOW   = 17'sd50;
    localparam logic signed [RATE_W-1:0] RATE_FAST = 15'sd20;

    localparam logic [DUTY_W-1:0] DUTY_FULL  = 4'd8;
    localparam logic [DUTY_W-1:0] DUTY_HIGH  = 4'd6;
    localparam logic [DUTY_W-1:0] DUTY_MID   = 4'd4;
    localparam logic [DUTY_W-1:0] DUTY_LOW   = 4'd2;
    localparam logic [DUTY_W-1:0] DUTY_NONE  = 4'd0;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [TARGET_W-1:0] target;
    } cfg_t;

endpackage

// File: hdl/thc_cfg_regs.sv
// Configuration registers: control mode and range-checked setpoint.
module thc_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    input  logic [thc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [thc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output thc_pkg::cfg_t                      cfg
);

    thc_pkg::cfg_t cfg_reg;
    thc_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                thc_pkg::REG_CONTROL_MODE: begin
                    cfg_next.mode = cfg_data[thc_pkg::MODE_W-1:0];
                end
                thc_pkg::REG_TARGET_TEMP: begin
                    // out-of-range setpoints are dropped
                    if (cfg_data inside {[thc_pkg::TARGET_MIN:thc_pkg::TARGET_MAX]}) begin
                        cfg_next.target = cfg_data[thc_pkg::TARGET_W-1:0];
                    end
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode   <= thc_pkg::CTRL_AUTO;
            cfg_reg.target <= thc_pkg::TARGET_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/thc_duty.sv
// Duty selection in eighths from setpoint error and rise rate.
module thc_duty (
    input  logic [thc_pkg::TARGET_W-1:0]        target,
    input  logic signed [thc_pkg::TEMP_W-1:0]   temperature,
    input  logic signed [thc_pkg::RATE_W-1:0]   rise_rate,
    output logic [thc_pkg::DUTY_W-1:0]          duty
);

    logic signed [thc_pkg::ERR_W-1:0] error;
    logic [thc_pkg::DUTY_W-1:0]       band_duty;
    logic                             slow_down;

    assign error = $signed({3'b000, target})
                 - $signed({{(thc_pkg::ERR_W-thc_pkg::TEMP_W){temperature[thc_pkg::TEMP_W-1]}},
                            temperature});

    always_comb begin
        if (error > thc_pkg::ERR_BAND_8) begin
            band_duty = thc_pkg::DUTY_FULL;
        end else if (error > thc_pkg::ERR_BAND_6) begin
            band_duty = thc_pkg::DUTY_HIGH;
        end else if (error > thc_pkg::ERR_BAND_4) begin
            band_duty = thc_pkg::DUTY_MID;
        end else if (error > thc_pkg::ERR_BAND_2) begin
            band_duty = thc_pkg::DUTY_LOW;
        end else begin
            band_duty = thc_pkg::DUTY_NONE;
        end
    end

    // rising fast while close to setpoint: back off by half
    assign slow_down = (rise_rate > thc_pkg::RATE_FAST) && (error < thc_pkg::ERR_SLOW);
    assign duty      = slow_down ? (band_duty >> 1) : band_duty;

endmodule

// File: hdl/thc_window.sv
// PWM window timer: holds the window start and compares elapsed time to duty.
module thc_window #(
    parameter int PERIOD_MS = thc_pkg::PERIOD_MS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              load,
    input  logic [thc_pkg::TIME_W-1:0]        now_ms,
    input  logic [thc_pkg::DUTY_W-1:0]        duty,
    output logic                              heat,
    output logic [thc_pkg::TIME_W-1:0]        window_start
);

    localparam int CMP_W = thc_pkg::TIME_W + thc_pkg::DUTY_W;
    localparam logic [thc_pkg::TIME_W-1:0] PERIOD = thc_pkg::TIME_W'(PERIOD_MS);

    logic [thc_pkg::TIME_W-1:0] window_start_reg;
    logic [thc_pkg::TIME_W-1:0] window_start_next;
    logic [thc_pkg::TIME_W-1:0] elapsed;
    logic [thc_pkg::TIME_W-1:0] elapsed_eff;
    logic                       wrap;
    logic [CMP_W-1:0]           elapsed_x8;
    logic [CMP_W-1:0]           on_limit;

    assign elapsed     = now_ms - window_start_reg;
    assign wrap        = (elapsed >= PERIOD);
    assign elapsed_eff = wrap ? '0 : elapsed;

    assign elapsed_x8 = {1'b0, elapsed_eff, 3'b000};
    assign on_limit   = CMP_W'(duty) * CMP_W'(PERIOD);
    assign heat       = (elapsed_x8 < on_limit);

    assign window_start_next = (load && wrap) ? now_ms : window_start_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_start_reg <= '0;
        end else begin
            window_start_reg <= window_start_next;
        end
    end

    assign window_start = window_start_reg;

endmodule

// File: hdl/thermostat_pwm_heater_control.sv
// Top level of the thermostat PWM heater controller.
//
//   channel   prefix  direction  carries
//   update    s_      in         temperature, rise_rate, now_ms, safety flags
//   result    m_      out        heat_on
//   config    cfg_    in         cfg_index, cfg_data (0 mode, 1 setpoint)
//
// One request per cycle while s_ready is high; a taken request passes through the input
// register, then the result register. The window start updates as a request
// moves into the result register, so the next request already sees it.
// Reset is synchronous, active low, and restores mode auto, setpoint 75.00, window 0.
// A stalled result holds the input register; s_ready drops only when both are full.
module thermostat_pwm_heater_control #(
    parameter int PERIOD_MS = thc_pkg::PERIOD_MS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [thc_pkg::TEMP_W-1:0]   s_temperature,
    input  logic signed [thc_pkg::RATE_W-1:0]   s_rise_rate,
    input  logic [thc_pkg::TIME_W-1:0]          s_now_ms,
    input  logic                                s_sensor_valid,
    input  logic                                s_occupied,
    input  logic                                s_hvac_busy,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_heat_on,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [thc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [thc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    thc_pkg::cfg_t cfg;

    logic                              in_valid_reg;
    logic                              in_valid_next;
    logic signed [thc_pkg::TEMP_W-1:0] in_temp_reg;
    logic signed [thc_pkg::RATE_W-1:0] in_rate_reg;
    logic [thc_pkg::TIME_W-1:0]        in_now_reg;
    logic                              in_sensor_reg;
    logic                              in_occupied_reg;
    logic                              in_busy_reg;

    logic                              m_valid_reg;
    logic                              m_valid_next;
    logic                              m_heat_on_reg;
    logic                              m_heat_on_next;

    logic                              advance;
    logic                              s_take;
    logic                              safe;
    logic                              auto_sel;
    logic                              forced_sel;
    logic                              win_load;
    logic                              win_heat;
    logic [thc_pkg::DUTY_W-1:0]        duty;
    logic [thc_pkg::TIME_W-1:0]        window_start;

    assign cfg_ready = 1'b1;

    thc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // result register can take a new value when empty or being drained
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    assign safe       = in_sensor_reg && in_occupied_reg && !in_busy_reg;
    assign auto_sel   = (cfg.mode == thc_pkg::CTRL_AUTO);
    assign forced_sel = (cfg.mode == thc_pkg::CTRL_FORCED);
    assign win_load   = in_valid_reg && advance && safe && auto_sel;

    thc_duty u_duty (
        .target      (cfg.target),
        .temperature (in_temp_reg),
        .rise_rate   (in_rate_reg),
        .duty        (duty)
    );

    thc_window #(
        .PERIOD_MS (PERIOD_MS)
    ) u_window (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (win_load),
        .now_ms       (in_now_reg),
        .duty         (duty),
        .heat         (win_heat),
        .window_start (window_start)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        m_valid_next   = advance ? in_valid_reg : m_valid_reg;
        m_heat_on_next = safe && (forced_sel || (auto_sel && win_heat));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_temp_reg     <= s_temperature;
            in_rate_reg     <= s_rise_rate;
            in_now_reg      <= s_now_ms;
            in_sensor_reg   <= s_sensor_valid;
            in_occupied_reg <= s_occupied;
            in_busy_reg     <= s_hvac_busy;
        end
        if (in_valid_reg && advance) begin
            m_heat_on_reg <= m_heat_on_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_heat_on = m_heat_on_reg;

    a_safety_forces_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && advance && !safe) |=> (m_valid && !m_heat_on))
        else $error("heat on after safety override");

    a_window_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !win_load |=> $stable(window_start))
        else $error("window start moved without an auto request");

    a_ready_low_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && m_valid_reg))
        else $error("input stalled with free room");

    a_target_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg.target >= thc_pkg::TARGET_MIN) && (cfg.target <= thc_pkg::TARGET_MAX))
        else $error("setpoint out of range");

endmodule

// File: tb/thermostat_pwm_heater_control_tb.sv
// Self-checking testbench for the thermostat PWM heater controller.
`timescale 1ns / 1ps

module thermostat_pwm_heater_control_tb;

    localparam int PERIOD      = thc_pkg::PERIOD_MS_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 100;

    // spare mode code, which the block treats as off, and register slots that it must ignore
    localparam logic [thc_pkg::MODE_W-1:0]    MODE_SPARE   = 2'd3;
    localparam logic [thc_pkg::CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [thc_pkg::CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

    typedef struct {
        logic signed [thc_pkg::TEMP_W-1:0] temperature;
        logic signed [thc_pkg::RATE_W-1:0] rise_rate;
        logic [thc_pkg::TIME_W-1:0]        now_ms;
        logic                              sensor_valid;
        logic                              occupied;
        logic                              hvac_busy;
    } update_t;

    typedef struct {
        logic [thc_pkg::CFG_IDX_W-1:0]  idx;
        logic [thc_pkg::CFG_DATA_W-1:0] data;
    } reg_write_t;

    typedef enum {RX_OPEN, RX_COIN, RX_PERIODIC, RX_CHOKE} rx_style_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                              s_valid = 1'b0;
    logic                              s_ready;
    logic signed [thc_pkg::TEMP_W-1:0] s_temperature = '0;
    logic signed [thc_pkg::RATE_W-1:0] s_rise_rate = '0;
    logic [thc_pkg::TIME_W-1:0]        s_now_ms = '0;
    logic                              s_sensor_valid = 1'b0;
    logic                              s_occupied = 1'b0;
    logic                              s_hvac_busy = 1'b0;

    logic m_valid;
    logic m_ready = 1'b0;
    logic m_heat_on;

    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [thc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [thc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // expected behavior: configuration and window state as the block should hold them
    logic [thc_pkg::MODE_W-1:0]   cur_mode;
    logic [thc_pkg::TARGET_W-1:0] cur_target;
    logic [thc_pkg::TIME_W-1:0]   win_start;

    update_t    update_queue[$];
    logic       heat_expected[$];
    reg_write_t reg_writes[$];
    update_t    update_on_bus;

    logic [thc_pkg::TIME_W-1:0] sim_ms;
    int mismatches = 0;
    int n_results = 0;
    int n_queued = 0;
    int cycles = 0;
    int burst_left = 0;
    int gap_left = 0;
    rx_style_t rx_style = RX_OPEN;
    int rx_left = 0;
    int rx_phase = 0;

    thermostat_pwm_heater_control #(
        .PERIOD_MS(PERIOD)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_temperature  (s_temperature),
        .s_rise_rate    (s_rise_rate),
        .s_now_ms       (s_now_ms),
        .s_sensor_valid (s_sensor_valid),
        .s_occupied     (s_occupied),
        .s_hvac_busy    (s_hvac_busy),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_heat_on      (m_heat_on),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT) begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
        mismatches++;
    endtask

    // heater decision for one accepted request; advances the window state
    function automatic logic predict_heat(input update_t u);
        int err;
        int rate;
        int duty;
        logic [thc_pkg::TIME_W-1:0] elapsed;
        logic heat;
        heat = 1'b0;
        if (u.sensor_valid && u.occupied && !u.hvac_busy) begin
            if (cur_mode == thc_pkg::CTRL_FORCED) begin
                heat = 1'b1;
            end else if (cur_mode == thc_pkg::CTRL_AUTO) begin
                err  = int'(cur_target) - int'(u.temperature);
                rate = int'(u.rise_rate);
                if (err > 100) duty = 8;
                else if (err > 50) duty = 6;
                else if (err > 20) duty = 4;
                else if (err > 0) duty = 2;
                else duty = 0;
                if (rate > 20 && err < 50) duty = duty / 2;
                elapsed = u.now_ms - win_start;
                if (elapsed >= thc_pkg::TIME_W'(PERIOD)) begin
                    win_start = u.now_ms;
                    elapsed = '0;
                end
                // elapsed is below the period here, so int math cannot overflow
                heat = (int'(elapsed) * 8 < duty * PERIOD);
            end
        end
        return heat;
    endfunction

    function automatic void push_update(input int t, input int r,
                                        input logic [thc_pkg::TIME_W-1:0] now,
                                        input bit sv, input bit oc, input bit hb);
        update_t u;
        u.temperature  = thc_pkg::TEMP_W'(t);
        u.rise_rate    = thc_pkg::RATE_W'(r);
        u.now_ms       = now;
        u.sensor_valid = sv;
        u.occupied     = oc;
        u.hvac_busy    = hb;
        update_queue.push_back(u);
        n_queued++;
    endfunction

    // mostly plausible readings near the setpoint on a moving clock, some noise
    function automatic update_t random_update();
        update_t u;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) sim_ms += $urandom_range(0, 1500);
        else if (pick < 80) sim_ms += $urandom_range(9000, 11000);
        else if (pick < 88) sim_ms += 0;
        else if (pick < 93) sim_ms -= $urandom_range(1, 500);
        else sim_ms = $urandom;
        u.now_ms = sim_ms;
        if ($urandom_range(0, 4) != 0) begin
            u.temperature = thc_pkg::TEMP_W'(int'(cur_target) + 100
                                             - int'($urandom_range(0, 300)));
        end else begin
            u.temperature = thc_pkg::TEMP_W'($urandom);
        end
        if ($urandom_range(0, 4) < 3) begin
            u.rise_rate = thc_pkg::RATE_W'(int'($urandom_range(0, 90)) - 30);
        end else begin
            u.rise_rate = thc_pkg::RATE_W'($urandom);
        end
        if ($urandom_range(0, 99) < 85) begin
            {u.sensor_valid, u.occupied, u.hvac_busy} = 3'b110;
        end else begin
            {u.sensor_valid, u.occupied, u.hvac_busy} = 3'($urandom);
        end
        return u;
    endfunction

    function automatic void queue_reg(input logic [thc_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [thc_pkg::CFG_DATA_W-1:0] data);
        reg_write_t w;
        w.idx  = idx;
        w.data = data;
        reg_writes.push_back(w);
    endfunction

    // issue queued register writes back to back; called at a clock edge
    task automatic apply_reg_writes();
        reg_write_t w;
        while (reg_writes.size() > 0) begin
            w = reg_writes.pop_front();
            cfg_index <= w.idx;
            cfg_data  <= w.data;
            cfg_valid <= 1'b1;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            if (w.idx == thc_pkg::REG_CONTROL_MODE) begin
                cur_mode = w.data[thc_pkg::MODE_W-1:0];
            end else if (w.idx == thc_pkg::REG_TARGET_TEMP &&
                         w.data >= thc_pkg::TARGET_MIN && w.data <= thc_pkg::TARGET_MAX) begin
                cur_target = w.data[thc_pkg::TARGET_W-1:0];
            end
        end
        cfg_valid <= 1'b0;
    endtask

    // wait until every queued request has produced its result
    task automatic drain();
        while (n_results < n_queued) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // request driver: bursts of back-to-back requests separated by random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                heat_expected.push_back(predict_heat(update_on_bus));
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (update_queue.size() > 0) begin
                    update_on_bus = update_queue.pop_front();
                    s_temperature  <= update_on_bus.temperature;
                    s_rise_rate    <= update_on_bus.rise_rate;
                    s_now_ms       <= update_on_bus.now_ms;
                    s_sensor_valid <= update_on_bus.sensor_valid;
                    s_occupied     <= update_on_bus.occupied;
                    s_hvac_busy    <= update_on_bus.hvac_busy;
                    s_valid        <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 48);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stall pattern
    always @(posedge aclk) begin
        logic want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_results++;
                if (heat_expected.size() == 0) begin
                    report_mismatch($sformatf("result %0d: heat_on %b with no request pending",
                                              n_results, m_heat_on));
                end else begin
                    want = heat_expected.pop_front();
                    if (m_heat_on !== want) begin
                        report_mismatch($sformatf("result %0d: heat_on %b, expected %b",
                                                  n_results, m_heat_on, want));
                    end
                end
            end
            if (rx_left == 0) begin
                rx_style = rx_style_t'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 128);
            end else begin
                rx_left--;
            end
            rx_phase++;
            case (rx_style)
                RX_OPEN:     m_ready <= 1'b1;
                RX_COIN:     m_ready <= 1'($urandom);
                RX_PERIODIC: m_ready <= (rx_phase % 5) >= 2;
                default:     m_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        logic [thc_pkg::MODE_W-1:0] mode;
        int n_items;
        cur_mode   = thc_pkg::CTRL_AUTO;
        cur_target = thc_pkg::TARGET_RESET;
        win_start  = '0;
        sim_ms     = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: auto mode, setpoint 75.00; walk the error band edges
        push_update(7399, 0, 0, 1, 1, 0);
        push_update(7400, 0, 9999, 1, 1, 0);
        push_update(7449, 0, 7000, 1, 1, 0);
        push_update(7450, 0, 7500, 1, 1, 0);
        push_update(7479, 0, 4999, 1, 1, 0);
        push_update(7480, 0, 5000, 1, 1, 0);
        push_update(7499, 0, 2499, 1, 1, 0);
        push_update(7500, 0, 100, 1, 1, 0);
        push_update(7501, 0, 0, 1, 1, 0);
        // rising fast near the setpoint halves the duty
        push_update(7451, 21, 1000, 1, 1, 0);
        push_update(7451, 20, 3000, 1, 1, 0);
        push_update(7450, 21, 3000, 1, 1, 0);
        // window restart, then field extremes with a wrapped timestamp
        push_update(7300, 0, 10000, 1, 1, 0);
        push_update(-16384, 16383, 32'hFFFF_FFFF, 1, 1, 0);
        push_update(16383, -16384, 32'hFFFF_FFFF, 1, 1, 0);
        // safety overrides
        push_update(7300, 0, 32'hFFFF_FFFF, 0, 1, 0);
        push_update(7300, 0, 32'hFFFF_FFFF, 1, 0, 0);
        push_update(7300, 0, 32'hFFFF_FFFF, 1, 1, 1);
        drain();

        queue_reg(thc_pkg::REG_CONTROL_MODE, thc_pkg::CFG_DATA_W'(thc_pkg::CTRL_FORCED));
        apply_reg_writes();
        push_update(16383, 0, 5, 1, 1, 0);
        push_update(7300, 0, 6, 1, 1, 1);
        drain();

        queue_reg(thc_pkg::REG_CONTROL_MODE, thc_pkg::CFG_DATA_W'(thc_pkg::CTRL_OFF));
        apply_reg_writes();
        push_update(7000, 0, 7, 1, 1, 0);
        drain();

        queue_reg(thc_pkg::REG_CONTROL_MODE, thc_pkg::CFG_DATA_W'(MODE_SPARE));
        apply_reg_writes();
        push_update(7000, 0, 8, 1, 1, 0);
        drain();

        // out-of-range setpoints and unused slots are dropped
        queue_reg(thc_pkg::REG_TARGET_TEMP, 14'd4999);
        queue_reg(thc_pkg::REG_TARGET_TEMP, 14'd9001);
        queue_reg(thc_pkg::REG_TARGET_TEMP, 14'd0);
        queue_reg(thc_pkg::REG_TARGET_TEMP, 14'h3FFF);
        queue_reg(REG_UNUSED_A, 14'h3FFF);
        queue_reg(REG_UNUSED_B, 14'd0);
        queue_reg(thc_pkg::REG_CONTROL_MODE, thc_pkg::CFG_DATA_W'(thc_pkg::CTRL_AUTO));
        apply_reg_writes();
        push_update(7399, 0, 20000, 1, 1, 0);
        drain();
        queue_reg(thc_pkg::REG_TARGET_TEMP, thc_pkg::TARGET_MAX);
        apply_reg_writes();
        push_update(8899, 0, 20001, 1, 1, 0);
        drain();
        queue_reg(thc_pkg::REG_TARGET_TEMP, thc_pkg::TARGET_MIN);
        apply_reg_writes();
        push_update(4900, 0, 24000, 1, 1, 0);
        drain();

        sim_ms = 32'd24000;
        for (int p = 0; p < 8; p++) begin
            mode = (p == 2) ? thc_pkg::CTRL_FORCED : (p == 4) ? thc_pkg::CTRL_OFF :
                   (p == 6) ? MODE_SPARE : thc_pkg::CTRL_AUTO;
            if (p % 2 == 1) begin
                queue_reg(thc_pkg::REG_TARGET_TEMP, ($urandom_range(0, 1) == 0) ?
                          thc_pkg::CFG_DATA_W'($urandom_range(0, 4999)) :
                          thc_pkg::CFG_DATA_W'($urandom_range(9001, 16383)));
                queue_reg(($urandom_range(0, 1) == 0) ? REG_UNUSED_A : REG_UNUSED_B,
                          thc_pkg::CFG_DATA_W'($urandom));
            end
            if (p == 0) begin
                queue_reg(thc_pkg::REG_TARGET_TEMP, thc_pkg::TARGET_MIN);
            end else if (p == 1) begin
                queue_reg(thc_pkg::REG_TARGET_TEMP, thc_pkg::TARGET_MAX);
            end else begin
                queue_reg(thc_pkg::REG_TARGET_TEMP,
                          thc_pkg::CFG_DATA_W'($urandom_range(5000, 9000)));
            end
            if (p == 5) begin
                queue_reg(thc_pkg::REG_TARGET_TEMP,
                          thc_pkg::CFG_DATA_W'($urandom_range(9001, 16383)));
            end
            queue_reg(thc_pkg::REG_CONTROL_MODE, thc_pkg::CFG_DATA_W'(mode));
            apply_reg_writes();
            // cross the 32-bit timestamp wrap in one of the auto phases
            if (p == 3) sim_ms = 32'hFFFF_C000;
            n_items = (mode == thc_pkg::CTRL_AUTO) ? 260 : 50;
            for (int i = 0; i < n_items; i++) begin
                update_queue.push_back(random_update());
                n_queued++;
            end
            drain();
        end

        if (heat_expected.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", heat_expected.size()));
        end
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: thermostat_pwm_heater_control.f
hdl/thc_pkg.sv
hdl/thc_cfg_regs.sv
hdl/thc_duty.sv
hdl/thc_window.sv
hdl/thermostat_pwm_heater_control.sv
tb/thermostat_pwm_heater_control_tb.sv
